@@ hdl/sbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the serial bank mapper.
// No dependencies.
package sbm_pkg;

    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_PPU_READ  = 2'd2,
        OP_PPU_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_CONTROL  = 2'd0,
        TGT_CHR_LOW  = 2'd1,
        TGT_CHR_HIGH = 2'd2,
        TGT_PRG      = 2'd3
    } target_t;

    typedef enum logic [0:0] {
        CFG_PRG_COUNT = 1'b0,
        CFG_CHR_COUNT = 1'b1
    } cfg_index_t;

    localparam int CountW   = 5;
    localparam int AddrW    = 16;
    localparam int DataW    = 8;
    localparam int MappedW  = 18;

    localparam logic [4:0] ControlReset = 5'h1C;
    localparam logic [4:0] ForceMode3   = 5'h0C;
    localparam logic [4:0] PrgCountReset = 5'd8;
    localparam logic [4:0] ChrCountReset = 5'd0;

    // Bank state as seen by the translation logic.
    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [3:0] chr_8k;
        logic [2:0] prg_32k;
        logic [3:0] prg_low;
        logic [3:0] prg_high;
    } bank_state_t;

    typedef struct packed {
        logic [MappedW-1:0] mapped_address;
        logic               hit;
        logic [1:0]         mirror_mode;
    } result_t;

    function automatic logic [3:0] last_bank(input logic [CountW-1:0] prg_count);
        logic [CountW-1:0] dec;
        dec = prg_count - CountW'(1);
        return dec[3:0];
    endfunction

endpackage

@@ hdl/sbm_regs.sv @@
`timescale 1ns / 1ps
// Serial load port and bank registers of the mapper.
// Depends on sbm_pkg.
module sbm_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  sbm_pkg::op_t                  operation,
    input  logic [sbm_pkg::AddrW-1:0]     address,
    input  logic [sbm_pkg::DataW-1:0]     write_data,
    input  logic [sbm_pkg::CountW-1:0]    prg_bank_count,
    output sbm_pkg::bank_state_t          banks,
    output logic [4:0]                    control_next
);

    sbm_pkg::bank_state_t banks_reg, banks_next;
    logic [4:0] shift_reg, shift_next;
    logic [2:0] count_reg, count_next;
    logic [4:0] load;
    logic [1:0] prg_mode;

    assign banks        = banks_reg;
    assign control_next = banks_next.control;
    assign load         = {write_data[0], shift_reg[4:1]};
    assign prg_mode     = banks_reg.control[3:2];

    always_comb
    begin
        banks_next = banks_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (step && operation == sbm_pkg::OP_CPU_WRITE && address[15])
        begin
            if (write_data[7])
            begin
                shift_next = '0;
                count_next = '0;
                banks_next.control = banks_reg.control | sbm_pkg::ForceMode3;
            end
            else if (count_reg != 3'd4)
            begin
                shift_next = load;
                count_next = count_reg + 3'd1;
            end
            else
            begin
                shift_next = '0;
                count_next = '0;
                unique case (sbm_pkg::target_t'(address[14:13]))
                    sbm_pkg::TGT_CONTROL:
                        banks_next.control = load;
                    sbm_pkg::TGT_CHR_LOW:
                        if (banks_reg.control[4])
                            banks_next.chr_low = load;
                        else
                            banks_next.chr_8k = load[4:1];
                    sbm_pkg::TGT_CHR_HIGH:
                        if (banks_reg.control[4])
                            banks_next.chr_high = load;
                    sbm_pkg::TGT_PRG:
                        priority if (!prg_mode[1])
                            banks_next.prg_32k = load[3:1];
                        else if (!prg_mode[0])
                        begin
                            banks_next.prg_low  = '0;
                            banks_next.prg_high = load[3:0];
                        end
                        else
                        begin
                            banks_next.prg_low  = load[3:0];
                            banks_next.prg_high = sbm_pkg::last_bank(prg_bank_count);
                        end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg          <= '0;
            count_reg          <= '0;
            banks_reg.control  <= sbm_pkg::ControlReset;
            banks_reg.chr_low  <= '0;
            banks_reg.chr_high <= '0;
            banks_reg.chr_8k   <= '0;
            banks_reg.prg_32k  <= '0;
            banks_reg.prg_low  <= '0;
            banks_reg.prg_high <= sbm_pkg::last_bank(sbm_pkg::PrgCountReset);
        end
        else
        begin
            shift_reg <= shift_next;
            count_reg <= count_next;
            banks_reg <= banks_next;
        end
    end

endmodule

@@ hdl/sbm_translate.sv @@
`timescale 1ns / 1ps
// Address translation for CPU program and PPU pattern accesses.
// Depends on sbm_pkg.
module sbm_translate
(
    input  sbm_pkg::op_t                      operation,
    input  logic [sbm_pkg::AddrW-1:0]         address,
    input  sbm_pkg::bank_state_t              banks,
    input  logic [sbm_pkg::CountW-1:0]        prg_bank_count,
    input  logic [sbm_pkg::CountW-1:0]        chr_bank_count,
    output logic [sbm_pkg::MappedW-1:0]       mapped_address,
    output logic                              hit
);

    logic [1:0] prg_mode;
    logic [3:0] bank16;
    logic       chr_ram;
    logic       ppu_low;

    assign prg_mode = banks.control[3:2];
    assign chr_ram  = (chr_bank_count == '0);
    assign ppu_low  = (address[15:13] == 3'd0);

    always_comb
    begin
        if (!address[14])
            bank16 = (prg_mode == 2'd2) ? 4'd0 : banks.prg_low;
        else
            bank16 = (prg_mode == 2'd3) ? sbm_pkg::last_bank(prg_bank_count)
                                        : banks.prg_high;
    end

    always_comb
    begin
        mapped_address = '0;
        hit            = 1'b0;
        unique case (operation)
            sbm_pkg::OP_CPU_READ:
                if (address[15])
                begin
                    hit = 1'b1;
                    if (!prg_mode[1])
                        mapped_address = {banks.prg_32k, address[14:0]};
                    else
                        mapped_address = {bank16, address[13:0]};
                end
            sbm_pkg::OP_CPU_WRITE: ;
            sbm_pkg::OP_PPU_READ:
                if (ppu_low)
                begin
                    hit = 1'b1;
                    if (chr_ram)
                        mapped_address = {5'd0, address[12:0]};
                    else if (banks.control[4])
                        mapped_address = {1'b0,
                            (address[12] ? banks.chr_high : banks.chr_low), address[11:0]};
                    else
                        mapped_address = {1'b0, banks.chr_8k, address[12:0]};
                end
            sbm_pkg::OP_PPU_WRITE:
                if (ppu_low && chr_ram)
                begin
                    hit            = 1'b1;
                    mapped_address = {5'd0, address[12:0]};
                end
            default: ;
        endcase
    end

endmodule

@@ hdl/serial_bank_mapper_unit.sv @@
`timescale 1ns / 1ps
// Serial bank mapper top level: input register, translation, result register.
// The input register captures an accepted access; the result register loads it when the output can advance.
// Throughput: one bus access per cycle while the output is not stalled; bank state updates in the result stage.
// Reset (async, active low): empty pipeline, control 0x1C, PRG counts 8, CHR 0.
// Depends on sbm_pkg, sbm_regs, sbm_translate.
module serial_bank_mapper_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // mapped_address[17:0], mirror_mode[19:18], zero
    output logic        m_axis_tuser,   // hit

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    logic                            in_valid_reg;
    sbm_pkg::op_t                    op_reg;
    logic [sbm_pkg::AddrW-1:0]       addr_reg;
    logic [sbm_pkg::DataW-1:0]       wdata_reg;
    logic                            out_valid_reg;
    sbm_pkg::result_t                result_reg, result_next;
    logic [sbm_pkg::MappedW-1:0]     mapped_next;
    logic                            hit_next;
    logic [sbm_pkg::CountW-1:0]      prg_count_reg, chr_count_reg;
    logic                            advance, step;
    sbm_pkg::bank_state_t            banks;
    logic [4:0]                      control_next;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    sbm_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .operation      (op_reg),
        .address        (addr_reg),
        .write_data     (wdata_reg),
        .prg_bank_count (prg_count_reg),
        .banks          (banks),
        .control_next   (control_next)
    );

    sbm_translate u_translate
    (
        .operation      (op_reg),
        .address        (addr_reg),
        .banks          (banks),
        .prg_bank_count (prg_count_reg),
        .chr_bank_count (chr_count_reg),
        .mapped_address (mapped_next),
        .hit            (hit_next)
    );

    assign result_next = {mapped_next, hit_next, control_next[1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_count_reg <= sbm_pkg::PrgCountReset;
            chr_count_reg <= sbm_pkg::ChrCountReset;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (cfg_we)
            begin
                unique case (sbm_pkg::cfg_index_t'(cfg_index))
                    sbm_pkg::CFG_PRG_COUNT: prg_count_reg <= cfg_data;
                    sbm_pkg::CFG_CHR_COUNT: chr_count_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg    <= sbm_pkg::op_t'(s_axis_tuser);
            addr_reg  <= s_axis_tdata[15:0];
            wdata_reg <= s_axis_tdata[23:16];
        end
        if (step)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, result_reg.mirror_mode, result_reg.mapped_address};
    assign m_axis_tuser  = result_reg.hit;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for serial_bank_mapper_unit: directed and random bus accesses through
// several bank-count settings, each result checked against an in-bench mapping model.
// Depends on sbm_pkg and the mapper RTL.
module tb;

    localparam logic [1:0] PrgFixFirst = 2'd2;
    localparam logic [1:0] PrgFixLast  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;

    // mapper model state
    logic [4:0] prg_count;
    logic [4:0] chr_count;
    logic [4:0] shift_bits;
    logic [2:0] shift_count;
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] chr_8k;
    logic [2:0] prg_32k;
    logic [3:0] prg_low;
    logic [3:0] prg_high;

    sbm_pkg::result_t expected_words[$];
    int unsigned      mismatch_count = 0;
    int unsigned      phase_items = 0;
    bit               no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    serial_bank_mapper_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [3:0] top_prg_bank();
        logic [4:0] dec;
        dec = prg_count - 5'd1;
        return dec[3:0];
    endfunction

    function automatic void shift_serial(logic [15:0] addr, logic [7:0] wdata);
        logic [4:0] load;
        if (wdata[7])
        begin
            shift_bits = '0;
            shift_count = '0;
            control = control | sbm_pkg::ForceMode3;
        end
        else
        begin
            load = {wdata[0], shift_bits[4:1]};
            shift_bits = load;
            shift_count = shift_count + 3'd1;
            if (shift_count == 3'd5)
            begin
                case (sbm_pkg::target_t'(addr[14:13]))
                    sbm_pkg::TGT_CONTROL: control = load;
                    sbm_pkg::TGT_CHR_LOW:
                    begin
                        if (control[4])
                            chr_low = load;
                        else
                            chr_8k = load[4:1];
                    end
                    sbm_pkg::TGT_CHR_HIGH:
                    begin
                        if (control[4])
                            chr_high = load;
                    end
                    default:
                    begin
                        if (!control[3])
                            prg_32k = load[3:1];
                        else if (control[3:2] == PrgFixFirst)
                        begin
                            prg_low = '0;
                            prg_high = load[3:0];
                        end
                        else
                        begin
                            prg_low = load[3:0];
                            prg_high = top_prg_bank();
                        end
                    end
                endcase
                shift_bits = '0;
                shift_count = '0;
            end
        end
    endfunction

    function automatic sbm_pkg::result_t map_access(sbm_pkg::op_t op, logic [15:0] addr,
                                                    logic [7:0] wdata);
        sbm_pkg::result_t r;
        logic [3:0]       bank;
        r = '0;
        case (op)
            sbm_pkg::OP_CPU_READ:
            begin
                if (addr[15])
                begin
                    r.hit = 1'b1;
                    if (!control[3])
                        r.mapped_address = {prg_32k, addr[14:0]};
                    else
                    begin
                        if (!addr[14])
                            bank = (control[3:2] == PrgFixFirst) ? 4'd0 : prg_low;
                        else
                            bank = (control[3:2] == PrgFixLast) ? top_prg_bank() : prg_high;
                        r.mapped_address = {bank, addr[13:0]};
                    end
                end
            end
            sbm_pkg::OP_CPU_WRITE:
            begin
                if (addr[15])
                    shift_serial(addr, wdata);
            end
            sbm_pkg::OP_PPU_READ:
            begin
                if (addr < 16'h2000)
                begin
                    r.hit = 1'b1;
                    if (chr_count == 5'd0)
                        r.mapped_address = {2'b00, addr};
                    else if (control[4])
                        r.mapped_address = {1'b0, (addr[12] ? chr_high : chr_low), addr[11:0]};
                    else
                        r.mapped_address = {1'b0, chr_8k, addr[12:0]};
                end
            end
            default:
            begin
                if (addr < 16'h2000 && chr_count == 5'd0)
                begin
                    r.hit = 1'b1;
                    r.mapped_address = {2'b00, addr};
                end
            end
        endcase
        r.mirror_mode = control[1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_access(sbm_pkg::op_t op, logic [15:0] addr, logic [7:0] wdata);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {wdata, addr};
        s_axis_tuser <= op;
        do @(posedge clk); while (!s_axis_tready);
        expected_words.push_back(map_access(op, addr, wdata));
        phase_items++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // five serial writes, LSB first; the last address picks the target
    task automatic load_register(sbm_pkg::target_t tgt, logic [4:0] value);
        for (int i = 0; i < 5; i++)
        begin
            if (i == 4)
                send_access(sbm_pkg::OP_CPU_WRITE, {1'b1, tgt, 13'($urandom)},
                            {1'b0, 6'($urandom), value[i]});
            else
                send_access(sbm_pkg::OP_CPU_WRITE, {1'b1, 15'($urandom)},
                            {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic send_lookup();
        logic [15:0]  addr;
        sbm_pkg::op_t op;
        case ($urandom_range(0, 2))
            0: op = sbm_pkg::OP_CPU_READ;
            1: op = sbm_pkg::OP_PPU_READ;
            default: op = sbm_pkg::OP_PPU_WRITE;
        endcase
        addr = 16'($urandom);
        if ($urandom_range(0, 4) != 0)
            addr = (op == sbm_pkg::OP_CPU_READ) ? (addr | 16'h8000) : (addr & 16'h1FFF);
        send_access(op, addr, 8'($urandom));
    endtask

    task automatic set_bank_counts(logic [4:0] prg, logic [4:0] chr);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= sbm_pkg::CFG_PRG_COUNT;
        cfg_data <= prg;
        @(posedge clk);
        cfg_index <= sbm_pkg::CFG_CHR_COUNT;
        cfg_data <= chr;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        prg_count = prg;
        chr_count = chr;
    endtask

    task automatic test_power_up_map();
        send_access(sbm_pkg::OP_CPU_READ, 16'h8000, 8'h00);
        send_access(sbm_pkg::OP_CPU_READ, 16'hFFFF, 8'hFF);
        send_access(sbm_pkg::OP_CPU_READ, 16'h7FFF, 8'h00);
        send_access(sbm_pkg::OP_PPU_READ, 16'h0000, 8'h00);
        send_access(sbm_pkg::OP_PPU_READ, 16'h2000, 8'h00);
        send_access(sbm_pkg::OP_PPU_WRITE, 16'h1FFF, 8'h5A);
    endtask

    task automatic test_serial_loads();
        send_access(sbm_pkg::OP_CPU_WRITE, 16'h7FFF, 8'h01);
        send_access(sbm_pkg::OP_CPU_WRITE, 16'h8000, 8'h01);
        send_access(sbm_pkg::OP_CPU_WRITE, 16'h8000, 8'h01);
        send_access(sbm_pkg::OP_CPU_WRITE, 16'hFFFF, 8'hFF);
        load_register(sbm_pkg::TGT_CONTROL, 5'h0A);
        load_register(sbm_pkg::TGT_PRG, 5'h0F);
        send_access(sbm_pkg::OP_CPU_READ, 16'h8000, 8'h00);
        send_access(sbm_pkg::OP_CPU_READ, 16'hC000, 8'h00);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned pick;
        int unsigned n;
        phase_items = 0;
        while (phase_items < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_access(sbm_pkg::OP_CPU_WRITE, {1'b1, 15'($urandom)},
                                8'h80 | 8'($urandom));
                load_register(sbm_pkg::target_t'($urandom_range(0, 3)), 5'($urandom));
                n = $urandom_range(1, 3);
                repeat (n) send_lookup();
            end
            else if (pick < 58)
            begin
                // partial load, usually cut short by a port clear
                n = $urandom_range(1, 4);
                repeat (n) send_access(sbm_pkg::OP_CPU_WRITE, {1'b1, 15'($urandom)},
                                       {1'b0, 7'($urandom)});
                if ($urandom_range(0, 3) != 0)
                    send_access(sbm_pkg::OP_CPU_WRITE, {1'b1, 15'($urandom)},
                                8'h80 | 8'($urandom));
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_lookup();
            end
            else
                send_access(sbm_pkg::op_t'($urandom_range(0, 3)), 16'($urandom),
                            8'($urandom));
            if ($urandom_range(0, 79) == 0)
                wait_drained();
        end
    endtask

    task automatic test_bank_counts();
        logic [4:0] prg;
        logic [4:0] chr;
        for (int i = 0; i < 7; i++)
        begin
            case (i)
                0: begin prg = 5'd16; chr = 5'd16; end
                1: begin prg = 5'd1;  chr = 5'd0;  end
                2: begin prg = 5'd0;  chr = 5'd1;  end
                3: begin prg = 5'd15; chr = 5'd15; end
                4: begin prg = 5'd16; chr = 5'd0;  end
                5: begin prg = 5'd1;  chr = 5'd16; end
                default:
                begin
                    prg = 5'($urandom_range(1, 16));
                    chr = 5'($urandom_range(0, 16));
                end
            endcase
            set_bank_counts(prg, chr);
            no_idle = (i % 3 == 1);
            test_random_traffic(105);
        end
        no_idle = 1'b0;
    endtask

    // sink side: random stall before each word
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        sbm_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata, 0);
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata[17:0] != want.mapped_address)
                    report_mismatch("mapped_address", m_axis_tdata[17:0], want.mapped_address);
                if (m_axis_tuser != want.hit)
                    report_mismatch("hit", m_axis_tuser, want.hit);
                if (m_axis_tdata[19:18] != want.mirror_mode)
                    report_mismatch("mirror_mode", m_axis_tdata[19:18], want.mirror_mode);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        prg_count = sbm_pkg::PrgCountReset;
        chr_count = sbm_pkg::ChrCountReset;
        shift_bits = '0;
        shift_count = '0;
        control = sbm_pkg::ControlReset;
        chr_low = '0;
        chr_high = '0;
        chr_8k = '0;
        prg_32k = '0;
        prg_low = '0;
        prg_high = top_prg_bank();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_up_map();
        test_serial_loads();
        test_bank_counts();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
